@@ rtl/core/euler_yxz_view_matrix_core_defines.svh @@
// ----------------------------------------------------------------------------
// Euler Y-X-Z view matrix core: assertion macros
// Shared concurrent check macros, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef EULER_YXZ_VIEW_MATRIX_CORE_DEFINES_SVH
`define EULER_YXZ_VIEW_MATRIX_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EYXZ_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("euler_yxz_view_matrix_core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EYXZ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("euler_yxz_view_matrix_core: next-cycle check failed");

`endif

@@ rtl/core/eyxz_pkg.sv @@
// ----------------------------------------------------------------------------
// eyxz_pkg
// Constants, defaults and the Q30 multiply shared by the view matrix core.
// ----------------------------------------------------------------------------
package eyxz_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  // Pipeline depth of each unit.
  localparam int SINE_STAGES  = 7;
  localparam int BASIS_STAGES = 2;
  localparam int TRANS_STAGES = 2;

  // Quarter-wave sine polynomial coefficients, unsigned Q30.
  localparam logic [30:0] K1 = 31'd1686629713;
  localparam logic [30:0] K3 = 31'd693598669;
  localparam logic [30:0] K5 = 31'd85569306;
  localparam logic [30:0] K7 = 31'd5026987;
  localparam logic [30:0] K9 = 31'd172273;

  localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
  localparam logic [62:0] Q30_HALF = 63'h2000_0000;

  // Unsigned Q30 product, rounded half up.
  function automatic logic [31:0] q30_mul(input logic [30:0] a, input logic [30:0] b);
    logic [62:0] p;
    p = 63'(a) * 63'(b) + Q30_HALF;
    return p[61:30];
  endfunction

endpackage

@@ rtl/core/eyxz_sine_pipe.sv @@
// ----------------------------------------------------------------------------
// eyxz_sine_pipe
// Seven-stage binary-angle sine (or cosine) in Q(COEF_FRAC_BITS): the angle is
// mapped and registered, squared, then one Horner multiply per stage.
// ----------------------------------------------------------------------------
module eyxz_sine_pipe #(
  parameter int   ANGLE_BITS     = eyxz_pkg::ANGLE_BITS_DEF,
  parameter int   COEF_FRAC_BITS = eyxz_pkg::COEF_FRAC_BITS_DEF,
  parameter logic COSINE         = 1'b0
) (
  input  logic                              clk,
  input  logic [eyxz_pkg::SINE_STAGES-1:0]  en,
  input  logic [15:0]                       angle,
  output logic signed [COEF_FRAC_BITS+1:0]  value
);
  import eyxz_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int DS = 30 - COEF_FRAC_BITS;
  localparam logic [31:0] RND     = (32'(1) << DS) >> 1;
  localparam logic [31:0] COEF1   = 32'(1) << COEF_FRAC_BITS;
  localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);

  logic [ANGLE_BITS+15:0] ang_wide;
  logic [ANGLE_BITS-1:0]  ang;
  logic [1:0]             quad_in;
  logic [ANGLE_BITS-2:0]  off_m;
  logic [30:0]            t_in;

  logic [30:0] t_p  [1:6];
  logic [1:0]  q_p  [1:6];
  logic [30:0] sq_p [2:5];
  logic [31:0] sq_full;
  logic [30:0] h3, h4, h5, h6;
  logic [30:0] h3_next, h4_next, h5_next, h6_next;
  logic [31:0] m, r, rc;
  logic [30:0] mc;
  logic signed [CW-1:0] mag, value_next;

  // Mirror the offset in odd quadrants; cosine is a quarter turn ahead.
  always_comb begin
    ang_wide = {{ANGLE_BITS{1'b0}}, angle};
    ang      = ang_wide[ANGLE_BITS-1:0];
    quad_in  = ang[ANGLE_BITS-1:ANGLE_BITS-2] + {1'b0, COSINE};
    off_m    = {1'b0, ang[ANGLE_BITS-3:0]};
    if (quad_in[0]) begin
      off_m = QUARTER - off_m;
    end
    t_in = 31'(off_m) << (32 - ANGLE_BITS);
  end

  always_comb begin
    sq_full = q30_mul(t_p[1], t_p[1]);
    h3_next = 31'(32'(K7) - q30_mul(sq_p[2], K9));
    h4_next = 31'(32'(K5) - q30_mul(sq_p[3], h3));
    h5_next = 31'(32'(K3) - q30_mul(sq_p[4], h4));
    h6_next = 31'(32'(K1) - q30_mul(sq_p[5], h5));
  end

  always_comb begin
    m  = q30_mul(t_p[6], h6);
    mc = (m > Q30_ONE) ? Q30_ONE[30:0] : m[30:0];
    r  = (32'(mc) + RND) >> DS;
    rc = (r > COEF1) ? COEF1 : r;
    mag = rc[CW-1:0];
    value_next = q_p[6][1] ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_p[1] <= t_in;
      q_p[1] <= quad_in;
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k-1]) begin
        t_p[k] <= t_p[k-1];
        q_p[k] <= q_p[k-1];
      end
    end
    if (en[1]) sq_p[2] <= sq_full[30:0];
    for (int k = 3; k <= 5; k++) begin
      if (en[k-1]) sq_p[k] <= sq_p[k-1];
    end
    if (en[2]) h3 <= h3_next;
    if (en[3]) h4 <= h4_next;
    if (en[4]) h5 <= h5_next;
    if (en[5]) h6 <= h6_next;
    if (en[6]) value <= value_next;
  end

endmodule

@@ rtl/core/eyxz_basis.sv @@
// ----------------------------------------------------------------------------
// eyxz_basis
// Two-stage product network forming the nine Y-X-Z basis entries.
// ----------------------------------------------------------------------------
module eyxz_basis #(
  parameter int COEF_FRAC_BITS = eyxz_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [eyxz_pkg::BASIS_STAGES-1:0] en,
  input  logic signed [COEF_FRAC_BITS+1:0]  s1,
  input  logic signed [COEF_FRAC_BITS+1:0]  c1,
  input  logic signed [COEF_FRAC_BITS+1:0]  s2,
  input  logic signed [COEF_FRAC_BITS+1:0]  c2,
  input  logic signed [COEF_FRAC_BITS+1:0]  s3,
  input  logic signed [COEF_FRAC_BITS+1:0]  c3,
  output logic signed [COEF_FRAC_BITS+1:0]  basis [9]
);
  import eyxz_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam logic signed [2*CW-1:0] HALFP = (2*CW)'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [CW:0]     ONE_P = (CW+1)'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [CW:0]     ONE_N = -ONE_P;

  // Product of two Q(COEF_FRAC_BITS) values, rounded with ties away from zero.
  function automatic logic signed [CW-1:0] cmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    logic signed [2*CW-1:0] q;
    p = $signed({{CW{a[CW-1]}}, a}) * $signed({{CW{b[CW-1]}}, b});
    q = (p + HALFP - (2*CW)'(p[2*CW-1])) >>> COEF_FRAC_BITS;
    return q[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] clamp(input logic signed [CW:0] x);
    logic signed [CW:0] y;
    y = x;
    if (x > ONE_P) y = ONE_P;
    if (x < ONE_N) y = ONE_N;
    return y[CW-1:0];
  endfunction

  logic signed [CW-1:0] c1c3, s1s2, c2s3, c1s2, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2;
  logic signed [CW-1:0] s2_d, s3_d;
  logic signed [CW:0]   sum [9];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c1c3 <= cmul(c1, c3);
      s1s2 <= cmul(s1, s2);
      c2s3 <= cmul(c2, s3);
      c1s2 <= cmul(c1, s2);
      c3s1 <= cmul(c3, s1);
      c1s3 <= cmul(c1, s3);
      c2c3 <= cmul(c2, c3);
      s1s3 <= cmul(s1, s3);
      c2s1 <= cmul(c2, s1);
      c1c2 <= cmul(c1, c2);
      s2_d <= s2;
      s3_d <= s3;
    end
  end

  // Second factor of each triple product, then the row sums.
  always_comb begin
    sum[0] = (CW+1)'(c1c3) + (CW+1)'(cmul(s1s2, s3_d));
    sum[1] = (CW+1)'(c2s3);
    sum[2] = (CW+1)'(cmul(c1s2, s3_d)) - (CW+1)'(c3s1);
    sum[3] = (CW+1)'(cmul(c3s1, s2_d)) - (CW+1)'(c1s3);
    sum[4] = (CW+1)'(c2c3);
    sum[5] = (CW+1)'(cmul(c1c3, s2_d)) + (CW+1)'(s1s3);
    sum[6] = (CW+1)'(c2s1);
    sum[7] = -(CW+1)'(s2_d);
    sum[8] = (CW+1)'(c1c2);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 9; i++) begin
        basis[i] <= clamp(sum[i]);
      end
    end
  end

endmodule

@@ rtl/core/eyxz_translate.sv @@
// ----------------------------------------------------------------------------
// eyxz_translate
// Two-stage view translation: nine products, then row sums, negation,
// rounding and saturation. Also holds the basis alongside as output.
// ----------------------------------------------------------------------------
module eyxz_translate #(
  parameter int COEF_FRAC_BITS = eyxz_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [eyxz_pkg::TRANS_STAGES-1:0] en,
  input  logic signed [COEF_FRAC_BITS+1:0]  basis_in [9],
  input  logic signed [31:0]                px,
  input  logic signed [31:0]                py,
  input  logic signed [31:0]                pz,
  output logic signed [COEF_FRAC_BITS+1:0]  basis_out [9],
  output logic signed [31:0]                trans [3]
);
  import eyxz_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = CW + 32;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAXV = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic signed [PW-1:0] prod [9];
  logic signed [CW-1:0] basis_d [9];
  logic signed [31:0]   pos [3];
  logic signed [SW-1:0] sum [3];
  logic signed [SW-1:0] neg [3];
  logic signed [SW-1:0] rnd [3];
  logic signed [31:0]   trans_next [3];

  always_comb begin
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 9; i++) begin
        prod[i]    <= PW'(basis_in[i]) * PW'(pos[i % 3]);
        basis_d[i] <= basis_in[i];
      end
    end
  end

  // Rounding stays signed throughout so that negative sums shift arithmetically.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SW'(prod[3*r]) + SW'(prod[3*r+1]) + SW'(prod[3*r+2]);
      neg[r] = -sum[r];
      rnd[r] = (neg[r] + HALF - $signed(SW'(neg[r][SW-1]))) >>> COEF_FRAC_BITS;
      if (rnd[r] > MAXV) begin
        trans_next[r] = 32'sh7fff_ffff;
      end else if (rnd[r] < MINV) begin
        trans_next[r] = 32'sh8000_0000;
      end else begin
        trans_next[r] = rnd[r][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 9; i++) basis_out[i] <= basis_d[i];
      for (int r = 0; r < 3; r++) trans[r] <= trans_next[r];
    end
  end

endmodule

@@ rtl/core/euler_yxz_view_matrix_core.sv @@
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_core
// Camera view basis and view translation from position and Y-X-Z Euler angles.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | pos_x, pos_y, pos_z, pitch, yaw, roll
//   output  | out_valid / out_ready| right_*, upward_*, fwd_*, trans_*
//
// An input transfer passes through the sine pipelines, the basis products and
// the translation before the result is offered. One item may be transferred
// in every cycle while out_ready is high.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage moves on when it is empty or its successor moves, so a stalled
// output fills the pipe from the back and bubbles are squeezed out.
//
module euler_yxz_view_matrix_core #(
  parameter int ANGLE_BITS     = eyxz_pkg::ANGLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = eyxz_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [15:0]        pitch,
  input  logic [15:0]        yaw,
  input  logic [15:0]        roll,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] upward_x,
  output logic signed [15:0] upward_y,
  output logic signed [15:0] upward_z,
  output logic signed [15:0] fwd_x,
  output logic signed [15:0] fwd_y,
  output logic signed [15:0] fwd_z,
  output logic signed [31:0] trans_x,
  output logic signed [31:0] trans_y,
  output logic signed [31:0] trans_z
);
  import eyxz_pkg::*;

  `include "euler_yxz_view_matrix_core_defines.svh"

  localparam int CW     = COEF_FRAC_BITS + 2;
  localparam int B_LAST = SINE_STAGES + BASIS_STAGES;
  localparam int NST    = B_LAST + TRANS_STAGES;
  localparam logic signed [CW-1:0] COEF_POS = CW'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [CW-1:0] COEF_NEG = -COEF_POS;

  // Valid bit and advance enable of every stage.
  logic [NST:1] v;
  logic [NST:1] en;

  // Position travels beside the sine and basis stages.
  logic signed [31:0] px_p [1:B_LAST];
  logic signed [31:0] py_p [1:B_LAST];
  logic signed [31:0] pz_p [1:B_LAST];

  logic signed [CW-1:0] s1, c1, s2, c2, s3, c3;
  logic signed [CW-1:0] basis     [9];
  logic signed [CW-1:0] basis_out [9];
  logic signed [31:0]   trans     [3];

  // A stage may load when it holds nothing or its occupant leaves this cycle.
  always_comb begin
    en[NST] = !v[NST] || out_ready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px_p[1] <= pos_x;
      py_p[1] <= pos_y;
      pz_p[1] <= pos_z;
    end
    for (int k = 2; k <= B_LAST; k++) begin
      if (en[k]) begin
        px_p[k] <= px_p[k-1];
        py_p[k] <= py_p[k-1];
        pz_p[k] <= pz_p[k-1];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[NST];

  // Six sine pipelines: yaw gives s1/c1, pitch s2/c2 and roll s3/c3.
  eyxz_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS), .COSINE(1'b0))
    u_sin_yaw (.clk(clk), .en(en[SINE_STAGES:1]), .angle(yaw), .value(s1));
  eyxz_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS), .COSINE(1'b1))
    u_cos_yaw (.clk(clk), .en(en[SINE_STAGES:1]), .angle(yaw), .value(c1));
  eyxz_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS), .COSINE(1'b0))
    u_sin_pitch (.clk(clk), .en(en[SINE_STAGES:1]), .angle(pitch), .value(s2));
  eyxz_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS), .COSINE(1'b1))
    u_cos_pitch (.clk(clk), .en(en[SINE_STAGES:1]), .angle(pitch), .value(c2));
  eyxz_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS), .COSINE(1'b0))
    u_sin_roll (.clk(clk), .en(en[SINE_STAGES:1]), .angle(roll), .value(s3));
  eyxz_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS), .COSINE(1'b1))
    u_cos_roll (.clk(clk), .en(en[SINE_STAGES:1]), .angle(roll), .value(c3));

  eyxz_basis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_basis (
    .clk   (clk),
    .en    (en[B_LAST:SINE_STAGES+1]),
    .s1    (s1),
    .c1    (c1),
    .s2    (s2),
    .c2    (c2),
    .s3    (s3),
    .c3    (c3),
    .basis (basis)
  );

  eyxz_translate #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_translate (
    .clk       (clk),
    .en        (en[NST:B_LAST+1]),
    .basis_in  (basis),
    .px        (px_p[B_LAST]),
    .py        (py_p[B_LAST]),
    .pz        (pz_p[B_LAST]),
    .basis_out (basis_out),
    .trans     (trans)
  );

  // Basis entries leave as their low sixteen bits, sign-extended first.
  function automatic logic [15:0] to16(input logic signed [CW-1:0] b);
    logic [CW+15:0] e;
    e = {{16{b[CW-1]}}, b};
    return e[15:0];
  endfunction

  assign right_x  = to16(basis_out[0]);
  assign right_y  = to16(basis_out[1]);
  assign right_z  = to16(basis_out[2]);
  assign upward_x = to16(basis_out[3]);
  assign upward_y = to16(basis_out[4]);
  assign upward_z = to16(basis_out[5]);
  assign fwd_x    = to16(basis_out[6]);
  assign fwd_y    = to16(basis_out[7]);
  assign fwd_z    = to16(basis_out[8]);
  assign trans_x  = trans[0];
  assign trans_y  = trans[1];
  assign trans_z  = trans[2];

  // With the output stage empty every stage can advance, so input is open.
  `EYXZ_ASSERT_IMPLY(a_empty_out_opens_input, !out_valid, in_ready)
  // A blocked first stage is only blocked because the next one is full.
  `EYXZ_ASSERT_IMPLY(a_block_means_full, v[1] && !en[1], v[2])
  // A blocked first stage keeps its item.
  `EYXZ_ASSERT_NEXT(a_blocked_item_kept, v[1] && !en[1], v[1])
  // Sine and cosine of yaw never exceed unity in magnitude.
  `EYXZ_ASSERT_IMPLY(a_yaw_unit_range, v[SINE_STAGES],
    s1 <= COEF_POS && s1 >= COEF_NEG && c1 <= COEF_POS && c1 >= COEF_NEG)

endmodule
